// ===== hw/rtl/scl_pkg.sv =====
// Shared types and constants for the shell command-line lexer.
// Character codes, token kind codes, lexer mode encoding and the queued result entry.
// No dependencies.
package scl_pkg;

    // lexer modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_PEND_LT = 5'b01000,
        MODE_PEND_GT = 5'b10000
    } lex_mode_t;

    // token kinds
    localparam logic [2:0] KIND_WORD    = 3'd0;
    localparam logic [2:0] KIND_PIPE    = 3'd1;
    localparam logic [2:0] KIND_IN      = 3'd2;
    localparam logic [2:0] KIND_OUT     = 3'd3;
    localparam logic [2:0] KIND_HEREDOC = 3'd4;
    localparam logic [2:0] KIND_APPEND  = 3'd5;
    localparam logic [2:0] KIND_EOL     = 3'd6;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF_MAX = 8'h0d;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_PIPE   = 8'h7c;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] start_pos;
        logic [12:0] end_pos;
        logic        too_long;
        logic        last;
    } tok_t;

endpackage

// ===== hw/rtl/shell_command_line_lexer.sv =====
// Top level of the shell command-line lexer: character state machine and result queue.
// Depends on scl_pkg (mode enum, token kinds, character codes, tok_t).
//
// Usage:
//   Input channel (s_): one request per character, s_tdata[7:0] = ch; s_tuser = end_of_line.
//   An end-of-line request flushes any open word or held '<' / '>' and then yields an
//   end-of-line token; lexer state then returns to its reset values.
//   Output channel (m_): one request per token. m_tdata = {end_pos, start_pos}, m_tuser =
//   {too_long, token_kind}, m_tlast marks the final token caused by one input request.
//   A request yields zero, one or two tokens.
// Timing:
//   Each character is lexed in the cycle it is accepted; its tokens enter a 4-entry result
//   queue and are shown on m_ from it in order. One request per cycle is sustained while
//   each yields at most one token and the receiver takes one per cycle. s_tready is high while
//   two entries are free, so a stalled receiver fills the queue until the input side stops.
// Reset:
//   aresetn low (synchronous) empties the queue and returns the lexer to idle at position 0.
//   MAX_LINE sets the saturation point for positions; past it too_long is raised.
module shell_command_line_lexer #(
    parameter int MAX_LINE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] start_pos, [24:12] end_pos, [31:25] zero
    output logic [3:0]  m_tuser,   // [2:0] token_kind, [3] too_long
    output logic        m_tlast
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int SW = $clog2(MAX_LINE);
    localparam logic [PW-1:0] POS_MAX  = PW'(MAX_LINE);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE - 1);

    function automatic scl_pkg::tok_t mk_tok(logic [2:0] kind, logic [31:0] s,
                                             logic [31:0] e, logic tl);
        scl_pkg::tok_t t;
        t.kind      = kind;
        t.start_pos = s[11:0];
        t.end_pos   = e[12:0];
        t.too_long  = tl;
        t.last      = 1'b0;
        return t;
    endfunction

    scl_pkg::lex_mode_t mode_reg, mode_next;
    logic               qd_reg, qd_next;
    logic [SW-1:0]      ws_reg, ws_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               ovf_reg, ovf_next;

    scl_pkg::tok_t      tok_a, tok_b;
    logic               a_vld, b_vld;
    logic [PW-1:0]      cur, idx, ws_inc, eol_s;
    logic               go_idle, tl;
    logic [7:0]         c;
    logic               c_space, c_quote, c_op;

    scl_pkg::tok_t      q_reg [4];
    logic [1:0]         wp_reg, rp_reg;
    logic [2:0]         cnt_reg;
    logic               s_fire, m_fire;
    logic [1:0]         push_n;

    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 3'd2);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {7'd0, q_reg[rp_reg].end_pos, q_reg[rp_reg].start_pos};
    assign m_tuser  = {q_reg[rp_reg].too_long, q_reg[rp_reg].kind};
    assign m_tlast  = q_reg[rp_reg].last;

    assign c       = s_tdata;
    assign c_space = (c == scl_pkg::CH_SPACE) || (c >= scl_pkg::CH_TAB && c <= scl_pkg::CH_FF_MAX);
    assign c_quote = (c == scl_pkg::CH_SQUOTE) || (c == scl_pkg::CH_DQUOTE);
    assign c_op    = (c == scl_pkg::CH_LT) || (c == scl_pkg::CH_GT) || (c == scl_pkg::CH_PIPE);
    assign ws_inc  = PW'(ws_reg) + 1'b1;
    assign eol_s   = (pos_reg < POS_MAX) ? pos_reg : POS_LAST;

    always_comb begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        ws_next   = ws_reg;
        pos_next  = pos_reg;
        ovf_next  = ovf_reg;
        a_vld     = 1'b0;
        b_vld     = 1'b0;
        go_idle   = 1'b0;
        cur       = pos_reg;
        idx       = pos_reg;
        tl        = ovf_reg;
        tok_a     = mk_tok(scl_pkg::KIND_WORD, 32'd0, 32'd0, 1'b0);
        tok_b     = mk_tok(scl_pkg::KIND_WORD, 32'd0, 32'd0, 1'b0);
        if (s_tuser) begin
            unique case (mode_reg)
                scl_pkg::MODE_WORD, scl_pkg::MODE_QUOTED: begin
                    a_vld = 1'b1;
                    tok_a = mk_tok(scl_pkg::KIND_WORD, 32'(ws_reg), 32'(pos_reg), tl);
                end
                scl_pkg::MODE_PEND_LT: begin
                    a_vld = 1'b1;
                    tok_a = mk_tok(scl_pkg::KIND_IN, 32'(ws_reg), 32'(ws_inc), tl);
                end
                scl_pkg::MODE_PEND_GT: begin
                    a_vld = 1'b1;
                    tok_a = mk_tok(scl_pkg::KIND_OUT, 32'(ws_reg), 32'(ws_inc), tl);
                end
                default: begin
                    a_vld = 1'b0;
                end
            endcase
            b_vld     = 1'b1;
            tok_b     = mk_tok(scl_pkg::KIND_EOL, 32'(eol_s), 32'(pos_reg), tl);
            mode_next = scl_pkg::MODE_IDLE;
            qd_next   = 1'b0;
            ws_next   = '0;
            pos_next  = '0;
            ovf_next  = 1'b0;
        end else begin
            if (pos_reg >= POS_MAX) begin
                ovf_next = 1'b1;
                cur      = POS_MAX;
                idx      = POS_LAST;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            tl = ovf_next;
            unique case (mode_reg)
                scl_pkg::MODE_QUOTED: begin
                    if (c == (qd_reg ? scl_pkg::CH_DQUOTE : scl_pkg::CH_SQUOTE)) begin
                        mode_next = scl_pkg::MODE_WORD;
                    end
                end
                scl_pkg::MODE_WORD: begin
                    if (c_quote) begin
                        mode_next = scl_pkg::MODE_QUOTED;
                        qd_next   = (c == scl_pkg::CH_DQUOTE);
                    end else if (c_space || c_op) begin
                        a_vld     = 1'b1;
                        tok_a     = mk_tok(scl_pkg::KIND_WORD, 32'(ws_reg), 32'(cur), tl);
                        mode_next = scl_pkg::MODE_IDLE;
                        go_idle   = 1'b1;
                    end
                end
                scl_pkg::MODE_PEND_LT, scl_pkg::MODE_PEND_GT: begin
                    a_vld     = 1'b1;
                    mode_next = scl_pkg::MODE_IDLE;
                    if (c == ((mode_reg == scl_pkg::MODE_PEND_LT) ? scl_pkg::CH_LT
                                                                  : scl_pkg::CH_GT)) begin
                        tok_a = mk_tok((mode_reg == scl_pkg::MODE_PEND_LT) ?
                                       scl_pkg::KIND_HEREDOC : scl_pkg::KIND_APPEND,
                                       32'(ws_reg), 32'(idx) + 32'd1, tl);
                    end else begin
                        tok_a = mk_tok((mode_reg == scl_pkg::MODE_PEND_LT) ?
                                       scl_pkg::KIND_IN : scl_pkg::KIND_OUT,
                                       32'(ws_reg), 32'(ws_inc), tl);
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    mode_next = scl_pkg::MODE_IDLE;
                    go_idle   = 1'b1;
                end
            endcase
            if (go_idle && !c_space) begin
                if (c == scl_pkg::CH_PIPE) begin
                    b_vld = 1'b1;
                    tok_b = mk_tok(scl_pkg::KIND_PIPE, 32'(idx), 32'(idx) + 32'd1, tl);
                end else begin
                    ws_next = SW'(idx);
                    if (c == scl_pkg::CH_LT) begin
                        mode_next = scl_pkg::MODE_PEND_LT;
                    end else if (c == scl_pkg::CH_GT) begin
                        mode_next = scl_pkg::MODE_PEND_GT;
                    end else if (c_quote) begin
                        mode_next = scl_pkg::MODE_QUOTED;
                        qd_next   = (c == scl_pkg::CH_DQUOTE);
                    end else begin
                        mode_next = scl_pkg::MODE_WORD;
                    end
                end
            end
        end
        tok_a.last = !b_vld;
        tok_b.last = 1'b1;
    end

    assign push_n = s_fire ? (2'(a_vld) + 2'(b_vld)) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= scl_pkg::MODE_IDLE;
            qd_reg   <= 1'b0;
            ws_reg   <= '0;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
        end else begin
            if (s_fire) begin
                mode_reg <= mode_next;
                qd_reg   <= qd_next;
                ws_reg   <= ws_next;
                pos_reg  <= pos_next;
                ovf_reg  <= ovf_next;
            end
            wp_reg  <= wp_reg + push_n;
            rp_reg  <= rp_reg + 2'(m_fire);
            cnt_reg <= cnt_reg + 3'(push_n) - 3'(m_fire);
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (a_vld) begin
                q_reg[wp_reg] <= tok_a;
                if (b_vld) begin
                    q_reg[wp_reg + 2'd1] <= tok_b;
                end
            end else if (b_vld) begin
                q_reg[wp_reg] <= tok_b;
            end
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result queue overfilled");

    a_eol_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser |-> push_n != 2'd0)
        else $error("end of line produced no token");

    a_eol_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser |=> mode_reg == scl_pkg::MODE_IDLE && pos_reg == '0 && !ovf_reg)
        else $error("lexer state not cleared after end of line");

    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("position beyond saturation");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> pos_reg == POS_MAX)
        else $error("overflow flag without saturated position");

endmodule
